/* sv/sbmt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sbmt_pkg;

	localparam logic [6:0] MAX_RUN = 7'd64;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHIFT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_LBA = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DISC_LEN = 2'd2;

	localparam logic [4:0] SHIFT_RESET = 5'd12;

	// request actions
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// response status
	localparam logic ST_OK = 1'b0;
	localparam logic ST_RANGE = 1'b1;

	typedef struct packed {
		logic        action;
		logic [12:0] map_index;
		logic [15:0] map_entry;
		logic [31:0] lba_first;
		logic [6:0]  lba_count;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [31:0] phys_lba;
		logic        empty_block;
		logic [6:0]  filled_count;
		logic        last;
	} rsp_t;

	// one slot handed from the sequencer to the lookup pipeline
	typedef struct packed {
		logic        vld;
		logic        fixed;   // acknowledge or reject, no map lookup
		logic        status;
		logic        last;
		logic [31:0] off;     // offset of the LBA within its block
	} issue_t;

endpackage

`default_nettype wire

/* sv/sbmt_map_pipe.sv */
`timescale 1ns / 1ps
`default_nettype none

module sbmt_map_pipe #(
	parameter int unsigned MAP_DEPTH = 8192
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire sbmt_pkg::issue_t             iss,
	input  wire logic [$clog2(MAP_DEPTH)-1:0] rd_addr,
	output logic                              adv,
	input  wire logic                         wr_en,
	input  wire logic [$clog2(MAP_DEPTH)-1:0] wr_addr,
	input  wire logic [15:0]                  wr_data,
	input  wire logic [4:0]                   shift,
	input  wire logic [31:0]                  base,
	output logic                              rsp_valid,
	input  wire logic                         rsp_ready,
	output sbmt_pkg::rsp_t                    rsp
);

	logic [15:0] map_mem [MAP_DEPTH];

	sbmt_pkg::issue_t iss_s1;
	logic [15:0]      rdata_s1;

	logic        v_s2;
	logic        fixed_s2;
	logic        status_s2;
	logic        empty_s2;
	logic        last_s2;
	logic [31:0] part_s2;

	logic        rsp_valid_q;
	sbmt_pkg::rsp_t rsp_q;
	logic [6:0]  fill_q;

	logic [31:0] part_c;
	logic        empty_c;
	logic [6:0]  fill_nxt;

	// whole pipeline moves together; stalls only when the output is held
	assign adv = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (adv && iss.vld && !iss.fixed) begin
			rdata_s1 <= map_mem[rd_addr];
		end
	end

	// block bits and offset bits never overlap, so OR is the add
	assign part_c = iss_s1.fixed ? 32'd0 : ((32'(rdata_s1) << shift) | iss_s1.off);
	assign empty_c = !iss_s1.fixed && (rdata_s1 == 16'd0);
	assign fill_nxt = fill_q + 7'((!empty_s2 && !fixed_s2) ? 1 : 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= '0;
			v_s2 <= 1'b0;
			rsp_valid_q <= 1'b0;
			fill_q <= '0;
		end else if (adv) begin
			iss_s1 <= iss;
			v_s2 <= iss_s1.vld;
			rsp_valid_q <= v_s2;
			if (v_s2) begin
				fill_q <= last_s2 ? 7'd0 : fill_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fixed_s2 <= iss_s1.fixed;
			status_s2 <= iss_s1.status;
			empty_s2 <= empty_c;
			last_s2 <= iss_s1.last;
			part_s2 <= part_c;
			rsp_q.status <= status_s2;
			rsp_q.phys_lba <= (fixed_s2 || empty_s2) ? 32'd0 : (part_s2 + base);
			rsp_q.empty_block <= empty_s2;
			rsp_q.filled_count <= fixed_s2 ? 7'd0 : fill_nxt;
			rsp_q.last <= last_s2;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == sbmt_pkg::ST_RANGE |->
			rsp.phys_lba == 32'd0 && rsp.last && rsp.filled_count == 7'd0)
		else $error("reject response malformed");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.empty_block |-> rsp.phys_lba == 32'd0)
		else $error("empty block with nonzero physical LBA");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= sbmt_pkg::MAX_RUN)
		else $error("filled count overran run length");

endmodule

`default_nettype wire

/* sv/sparse_block_map_lba_translator.sv */
// Sparse block map translator. A write request (action 0) stores one 16-bit
// map entry and returns one acknowledge from S_FIX. A read request (action
// 1) is bounds checked in S_CALC and S_CHECK, then the map memory is read
// once per cycle when not stalled; the next request waits until the run is
// issued. Results pass the s1, s2 and output registers. The single-port
// read of the map memory sets the rate of one result per cycle when not
// stalled. A rejected run returns one result with status 1. Output stalls
// freeze the lookup pipeline. Reading a map entry never written returns
// whatever the memory holds. Configuration writes are always ready.
`timescale 1ns / 1ps
`default_nettype none

module sparse_block_map_lba_translator #(
	parameter int unsigned MAP_DEPTH = 8192
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_ready,
	input  wire sbmt_pkg::req_t                     req,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_ready,
	output sbmt_pkg::rsp_t                          rsp,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [sbmt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [31:0]                        cfg_data
);

	localparam int unsigned IDX_W = $clog2(MAP_DEPTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CALC  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_FIX   = 3'd3;
	localparam logic [2:0] S_RUN   = 3'd4;

	logic [2:0]  state_q;
	logic [4:0]  shift_q;
	logic [31:0] base_q;
	logic [31:0] disc_q;

	sbmt_pkg::req_t req_q;
	logic [32:0] end_q;
	logic [32:0] lastlba_q;
	logic        badcnt_q;
	logic        fixst_q;
	logic [31:0] lba_q;
	logic [6:0]  rem_q;

	sbmt_pkg::issue_t   iss;
	logic [IDX_W-1:0]   rd_addr;
	logic               adv;
	logic               req_acc;
	logic               wr_en;
	logic               bad;
	logic [31:0]        sh_lba;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= sbmt_pkg::SHIFT_RESET;
			base_q <= '0;
			disc_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sbmt_pkg::CFG_BLOCK_SHIFT: shift_q <= cfg_data[4:0];
				sbmt_pkg::CFG_BASE_LBA: base_q <= cfg_data;
				sbmt_pkg::CFG_DISC_LEN: disc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign req_acc = req_valid && req_ready;
	assign wr_en = req_acc && (req.action == sbmt_pkg::ACT_WRITE)
		&& (32'(req.map_index) < 32'(MAP_DEPTH));

	assign bad = badcnt_q || (end_q > {1'b0, disc_q})
		|| ((lastlba_q >> shift_q) >= 33'(MAP_DEPTH));

	assign sh_lba = lba_q >> shift_q;
	assign rd_addr = sh_lba[IDX_W-1:0];

	always_comb begin
		iss = '0;
		if (state_q == S_FIX) begin
			iss.vld = 1'b1;
			iss.fixed = 1'b1;
			iss.status = fixst_q;
			iss.last = 1'b1;
		end else if (state_q == S_RUN) begin
			iss.vld = 1'b1;
			iss.status = sbmt_pkg::ST_OK;
			iss.last = (rem_q == 7'd1);
			iss.off = lba_q & ~(32'hFFFF_FFFF << shift_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						state_q <= (req.action == sbmt_pkg::ACT_WRITE) ? S_FIX : S_CALC;
					end
				end
				S_CALC: state_q <= S_CHECK;
				S_CHECK: state_q <= bad ? S_FIX : S_RUN;
				S_FIX: begin
					if (adv) begin
						state_q <= S_IDLE;
					end
				end
				S_RUN: begin
					if (adv && rem_q == 7'd1) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_q <= req;
			fixst_q <= sbmt_pkg::ST_OK;
		end
		if (state_q == S_CALC) begin
			end_q <= {1'b0, req_q.lba_first} + 33'(req_q.lba_count);
			lastlba_q <= {1'b0, req_q.lba_first} + 33'(req_q.lba_count) - 33'd1;
			badcnt_q <= (req_q.lba_count == 7'd0) || (req_q.lba_count > sbmt_pkg::MAX_RUN);
		end
		if (state_q == S_CHECK) begin
			fixst_q <= sbmt_pkg::ST_RANGE;
			lba_q <= req_q.lba_first;
			rem_q <= req_q.lba_count;
		end
		if (state_q == S_RUN && adv) begin
			lba_q <= lba_q + 32'd1;
			rem_q <= rem_q - 7'd1;
		end
	end

	sbmt_map_pipe #(
		.MAP_DEPTH(MAP_DEPTH)
	) u_pipe (
		.clk(clk),
		.arst_n(arst_n),
		.iss(iss),
		.rd_addr(rd_addr),
		.adv(adv),
		.wr_en(wr_en),
		.wr_addr(IDX_W'(req.map_index)),
		.wr_data(req.map_entry),
		.shift(shift_q),
		.base(base_q),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> rem_q != 7'd0)
		else $error("run state with no LBAs left");

	a_write_ack: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req.action == sbmt_pkg::ACT_WRITE |=> state_q == S_FIX && !fixst_q)
		else $error("write transaction not acknowledged");

	a_run_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> 32'(sh_lba) < 32'(MAP_DEPTH))
		else $error("lookup beyond map depth");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned MAP_ENTRIES = 8192;
	localparam int unsigned PHASES = 7;
	localparam int unsigned PHASE_ITEMS = 70;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned STUCK_LIMIT = 3000;
	localparam int unsigned SETTLE_CYCLES = 16;

	localparam sbmt_pkg::rsp_t RSP_ACK = '{status: sbmt_pkg::ST_OK, phys_lba: 32'd0,
		empty_block: 1'b0, filled_count: 7'd0, last: 1'b1};
	localparam sbmt_pkg::rsp_t RSP_REJECT = '{status: sbmt_pkg::ST_RANGE, phys_lba: 32'd0,
		empty_block: 1'b0, filled_count: 7'd0, last: 1'b1};

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t       kind;
		sbmt_pkg::req_t  r;
		bit              typed;
		sbmt_pkg::rsp_t  want;
		logic [4:0]      shift;
		logic [31:0]     base;
		logic [31:0]     limit;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	sbmt_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	sbmt_pkg::rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [sbmt_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	sparse_block_map_lba_translator #(
		.MAP_DEPTH(MAP_ENTRIES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// translator state as the testbench sees it
	logic [15:0] block_map [MAP_ENTRIES];
	bit map_written [MAP_ENTRIES];
	logic [4:0] blk_shift = sbmt_pkg::SHIFT_RESET;
	logic [31:0] lba_base = '0;
	logic [31:0] lba_limit = '0;

	sbmt_pkg::rsp_t translation_buf [64];
	sbmt_pkg::rsp_t rsp_due [$];

	int mismatches = 0;
	int stuck_cycles = 0;
	bit req_burst = 1'b0;
	bit rsp_eager = 1'b0;
	int hold_requests = 0;
	int holds_done = 0;
	int hold_left = 0;
	int stall_left = 0;

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic sbmt_pkg::req_t mk_req(input logic action, input logic [12:0] idx,
			input logic [15:0] entry, input logic [31:0] first, input logic [6:0] count);
		sbmt_pkg::req_t r;
		r.action = action;
		r.map_index = idx;
		r.map_entry = entry;
		r.lba_first = first;
		r.lba_count = count;
		return r;
	endfunction

	function automatic sbmt_pkg::rsp_t mk_rsp(input logic st, input logic [31:0] phys,
			input logic empty, input logic [6:0] filled, input logic last);
		sbmt_pkg::rsp_t t;
		t.status = st;
		t.phys_lba = phys;
		t.empty_block = empty;
		t.filled_count = filled;
		t.last = last;
		return t;
	endfunction

	function automatic stim_row_t req_row(input sbmt_pkg::req_t r, input bit typed = 1'b0,
			input sbmt_pkg::rsp_t want = '0);
		stim_row_t row;
		row = '{kind: ROW_REQ, r: r, typed: typed, want: want, shift: '0, base: '0, limit: '0};
		return row;
	endfunction

	function automatic stim_row_t cfg_row(input logic [4:0] sh, input logic [31:0] base,
			input logic [31:0] limit);
		stim_row_t row;
		row = '{kind: ROW_CFG, r: '0, typed: 1'b0, want: '0, shift: sh, base: base,
			limit: limit};
		return row;
	endfunction

	// count must be 1 to MAX_RUN; end of run taken without wrap, checked against disc length and map depth
	function automatic bit run_ok(input sbmt_pkg::req_t r);
		logic [63:0] end_lba;
		end_lba = {32'd0, r.lba_first} + 64'(r.lba_count);
		return r.lba_count != 7'd0 && r.lba_count <= sbmt_pkg::MAX_RUN
			&& end_lba <= {32'd0, lba_limit}
			&& ((end_lba - 64'd1) >> blk_shift) < 64'(MAP_ENTRIES);
	endfunction

	// fills translation_buf with the results of one request, returns their number
	function automatic int translate_req(input sbmt_pkg::req_t r);
		logic [63:0] lba;
		logic [63:0] idx;
		logic [63:0] phys;
		logic [63:0] mask;
		logic [15:0] ent;
		logic [6:0] filled;
		filled = '0;
		mask = (64'd1 << blk_shift) - 64'd1;
		if (r.action == sbmt_pkg::ACT_WRITE) begin
			block_map[r.map_index] = r.map_entry;
			map_written[r.map_index] = 1'b1;
			translation_buf[0] = RSP_ACK;
			return 1;
		end
		if (!run_ok(r)) begin
			translation_buf[0] = RSP_REJECT;
			return 1;
		end
		for (int k = 0; k < int'(r.lba_count); k++) begin
			lba = {32'd0, r.lba_first} + 64'(k);
			idx = lba >> blk_shift;
			ent = block_map[idx[12:0]];
			if (ent == 16'd0) begin
				translation_buf[k] = mk_rsp(sbmt_pkg::ST_OK, 32'd0, 1'b1, filled,
					k + 1 == int'(r.lba_count));
			end else begin
				phys = ({48'd0, ent} << blk_shift) + (lba & mask) + {32'd0, lba_base};
				filled++;
				translation_buf[k] = mk_rsp(sbmt_pkg::ST_OK, phys[31:0], 1'b0, filled,
					k + 1 == int'(r.lba_count));
			end
		end
		return int'(r.lba_count);
	endfunction

	function automatic sbmt_pkg::req_t random_write();
		sbmt_pkg::req_t w;
		int sel;
		sel = $urandom_range(0, 9);
		w.action = sbmt_pkg::ACT_WRITE;
		if (sel < 6)
			w.map_index = 13'($urandom_range(0, 15));
		else if (sel < 8)
			w.map_index = 13'($urandom_range(MAP_ENTRIES - 16, MAP_ENTRIES - 1));
		else
			w.map_index = 13'($urandom);
		w.map_entry = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom);
		w.lba_first = $urandom;
		w.lba_count = 7'($urandom);
		return w;
	endfunction

	function automatic sbmt_pkg::req_t noise_read();
		return mk_req(sbmt_pkg::ACT_READ, 13'($urandom), 16'($urandom), $urandom,
			7'($urandom));
	endfunction

	// runs that land mostly on a small set of map entries near both ends of the map
	function automatic sbmt_pkg::req_t random_read();
		sbmt_pkg::req_t r;
		logic [63:0] mi;
		logic [63:0] first;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 70)
			mi = 64'($urandom_range(0, 15));
		else if (sel < 85)
			mi = 64'($urandom_range(MAP_ENTRIES - 16, MAP_ENTRIES - 1));
		else
			mi = 64'($urandom_range(0, MAP_ENTRIES - 1));
		first = (mi << blk_shift) + ({$urandom, $urandom} & ((64'd1 << blk_shift) - 64'd1));
		r = mk_req(sbmt_pkg::ACT_READ, 13'($urandom), 16'($urandom), first[31:0], 7'd1);
		sel = $urandom_range(0, 9);
		if (sel < 2)
			r.lba_count = 7'd64;
		else if (sel < 3)
			r.lba_count = 7'd1;
		else
			r.lba_count = 7'($urandom_range(1, 64));
		// hug the disc length from both sides
		if ($urandom_range(0, 9) == 0)
			r.lba_first = lba_limit - 32'(r.lba_count) + 32'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic void note_mismatch(input string what, input sbmt_pkg::rsp_t want,
			input sbmt_pkg::rsp_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"%0t %s: expected st=%0d phys=%h empty=%0d filled=%0d last=%0d,",
				" got st=%0d phys=%h empty=%0d filled=%0d last=%0d"},
				$time, what, want.status, want.phys_lba, want.empty_block, want.filled_count,
				want.last, got.status, got.phys_lba, got.empty_block, got.filled_count,
				got.last);
	endfunction

	task automatic send_req(input sbmt_pkg::req_t r);
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic pause_req();
		int n;
		n = 0;
		if (!req_burst && $urandom_range(0, 1) == 1)
			n = gap_len();
		if (n != 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic issue_item(input sbmt_pkg::req_t r, input bit typed,
			input sbmt_pkg::rsp_t want);
		int n;
		n = translate_req(r);
		if (typed)
			rsp_due.push_back(want);
		else
			for (int k = 0; k < n; k++)
				rsp_due.push_back(translation_buf[k]);
		send_req(r);
		pause_req();
	endtask

	// load every map entry that an accepted run will look up
	task automatic fill_map(input sbmt_pkg::req_t rd, inout int n);
		logic [63:0] idx;
		sbmt_pkg::req_t w;
		if (run_ok(rd)) begin
			for (int k = 0; k < int'(rd.lba_count); k++) begin
				idx = ({32'd0, rd.lba_first} + 64'(k)) >> blk_shift;
				if (!map_written[idx[12:0]]) begin
					w = random_write();
					w.map_index = idx[12:0];
					issue_item(w, 1'b0, '0);
					n++;
				end
			end
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (rsp_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [4:0] sh, input logic [31:0] base,
			input logic [31:0] limit);
		logic [sbmt_pkg::CFG_IDX_W-1:0] regs [3];
		logic [31:0] vals [3];
		regs = '{sbmt_pkg::CFG_BLOCK_SHIFT, sbmt_pkg::CFG_BASE_LBA, sbmt_pkg::CFG_DISC_LEN};
		vals = '{{27'd0, sh}, base, limit};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		blk_shift = sh;
		lba_base = base;
		lba_limit = limit;
	endtask

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else if (holds_done != hold_requests) begin
			// long back-pressure so the block fills up and stalls its input
			holds_done <= holds_done + 1;
			hold_left <= HOLD_CYCLES - 1;
			rsp_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_ready <= 1'b0;
		end else if (rsp_eager || $urandom_range(0, 9) < 7) begin
			rsp_ready <= 1'b1;
		end else begin
			stall_left <= gap_len() - 1;
			rsp_ready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		sbmt_pkg::rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (rsp_due.size() == 0) begin
				note_mismatch("result with nothing outstanding", '0, rsp);
			end else begin
				want = rsp_due.pop_front();
				if (rsp.status !== want.status || rsp.phys_lba !== want.phys_lba
						|| rsp.empty_block !== want.empty_block
						|| rsp.filled_count !== want.filled_count || rsp.last !== want.last)
					note_mismatch("result mismatch", want, rsp);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles == STUCK_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		stim_row_t rows [$];
		logic [4:0] sh;
		logic [31:0] base;
		logic [31:0] limit;
		sbmt_pkg::req_t r;
		int n;
		int sel;
		bit paused;

		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = sbmt_pkg::CFG_BLOCK_SHIFT;
		cfg_data = '0;

		// disc length is zero out of reset, so any run is rejected
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_READ, 13'd0, 16'd0, 32'd0, 7'd1),
			1'b1, RSP_REJECT));
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_WRITE, 13'd0, 16'hFFFF, 32'd0, 7'd0),
			1'b1, RSP_ACK));
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_WRITE, 13'(MAP_ENTRIES - 1), 16'd1,
			32'hFFFF_FFFF, 7'h7F), 1'b1, RSP_ACK));
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_WRITE, 13'd1, 16'd0, 32'd0, 7'd0),
			1'b1, RSP_ACK));
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_READ, 13'h1FFF, 16'hFFFF, 32'd0, 7'd0),
			1'b1, RSP_REJECT));
		rows.push_back(cfg_row(5'd12, 32'd0, 32'hFFFF_FFFF));
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_READ, 13'd0, 16'd0, 32'd0, 7'd64)));
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_READ, 13'd0, 16'd0, 32'd4096, 7'd3)));
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_READ, 13'd0, 16'd0, 32'd4094, 7'd4)));
		// last LBA on the last map entry, then one past it
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_READ, 13'd0, 16'd0, 32'h01FF_FFFA,
			7'd6)));
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_READ, 13'd0, 16'd0, 32'h01FF_FFFB,
			7'd6), 1'b1, RSP_REJECT));
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_READ, 13'd0, 16'd0, 32'd0, 7'd65),
			1'b1, RSP_REJECT));
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_READ, 13'd0, 16'd0, 32'd0, 7'd127),
			1'b1, RSP_REJECT));
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_READ, 13'd0, 16'd0, 32'hFFFF_FFFF,
			7'd64), 1'b1, RSP_REJECT));
		rows.push_back(cfg_row(5'd12, 32'hFFFF_FFFF, 32'd100));
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_READ, 13'd0, 16'd0, 32'd36, 7'd64)));
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_READ, 13'd0, 16'd0, 32'd37, 7'd64),
			1'b1, RSP_REJECT));
		rows.push_back(cfg_row(5'd0, 32'd0, 32'hFFFF_FFFF));
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_READ, 13'd0, 16'd0, 32'd0, 7'd2)));
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_READ, 13'd0, 16'd0,
			32'(MAP_ENTRIES - 1), 7'd1)));
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_READ, 13'd0, 16'd0,
			32'(MAP_ENTRIES - 1), 7'd2), 1'b1, RSP_REJECT));
		// largest shift, physical LBA wraps
		rows.push_back(cfg_row(5'd31, 32'h1234_5678, 32'hFFFF_FFFF));
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_READ, 13'd0, 16'd0, 32'h7FFF_FFFE,
			7'd4)));
		rows.push_back(cfg_row(5'd23, 32'd0, 32'hFFFF_FFFF));
		rows.push_back(req_row(mk_req(sbmt_pkg::ACT_READ, 13'd0, 16'd0, 32'h007F_FFFF,
			7'd2)));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				drain();
				set_config(rows[i].shift, rows[i].base, rows[i].limit);
			end else begin
				issue_item(rows[i].r, rows[i].typed, rows[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					sh = 5'd0;
					base = '1;
					limit = '1;
				end
				1: begin
					sh = 5'd23;
					base = '0;
					limit = '1;
				end
				2: begin
					sh = 5'($urandom_range(1, 22));
					base = $urandom;
					limit = $urandom;
				end
				3: begin
					sh = 5'($urandom_range(24, 31));
					base = $urandom;
					limit = '1;
				end
				4: begin
					sh = 5'd12;
					base = $urandom;
					limit = MAP_ENTRIES << 12;
				end
				5: begin
					sh = 5'($urandom_range(0, 23));
					base = $urandom;
					limit = '1;
				end
				default: begin
					// zero disc length: every run is rejected
					sh = 5'($urandom_range(0, 31));
					base = $urandom;
					limit = '0;
				end
			endcase
			drain();
			set_config(sh, base, limit);
			req_burst = (ph == 1 || ph == 4);
			rsp_eager = (ph == 1 || ph == 4);
			if (ph == 5)
				hold_requests++;
			n = 0;
			paused = 1'b0;
			while (n < PHASE_ITEMS) begin
				if (ph == 2 && !paused && n >= PHASE_ITEMS / 2) begin
					drain();
					paused = 1'b1;
				end
				sel = $urandom_range(0, 99);
				if (sel < 25)
					r = random_write();
				else if (sel < 30)
					r = noise_read();
				else
					r = random_read();
				if (r.action == sbmt_pkg::ACT_READ)
					fill_map(r, n);
				issue_item(r, 1'b0, '0);
				n++;
			end
		end

		drain();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
